FILE: rtl/core/jst_pkg.sv
// Package with shared types and constants of the JSON syntax tokenizer.
package jst_pkg;

  localparam int unsigned MaxDepth = 32;
  localparam int unsigned DepthW   = 6;
  localparam int unsigned PtrW     = 5;
  localparam int unsigned QDepth   = 2;

  typedef enum logic [3:0] {
    M_VALUE, M_ARR_FIRST, M_OBJ_FIRST, M_KEY, M_COLON, M_AFTER,
    M_NULL, M_TRUE, M_FALSE, M_NUM, M_STR, M_KEYSTR
  } mode_e;

  typedef enum logic [3:0] {
    EV_NONE = 4'd0, EV_NULL = 4'd1, EV_TRUE = 4'd2, EV_FALSE = 4'd3,
    EV_STR_OPEN = 4'd4, EV_STR_CHAR = 4'd5, EV_STR_CLOSE = 4'd6,
    EV_KEY_CLOSE = 4'd7, EV_NUM_CHAR = 4'd8, EV_ARR_OPEN = 4'd9,
    EV_ARR_CLOSE = 4'd10, EV_OBJ_OPEN = 4'd11, EV_OBJ_CLOSE = 4'd12,
    EV_COMMA = 4'd13, EV_COLON = 4'd14, EV_LIT_CHAR = 4'd15
  } event_e;

  typedef enum logic [2:0] {
    ST_RUN = 3'd0, ST_OK = 3'd1, ST_INVALID = 3'd2, ST_EXPECT = 3'd3,
    ST_NOT_SINGULAR = 3'd4, ST_TOO_DEEP = 3'd5
  } status_e;

  // Byte classification produced by the front end.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
    logic       is_ws;
    logic       is_digit;
    logic       is_exp;
  } item_t;

  typedef struct packed {
    logic [3:0]        event_res;
    logic [7:0]        char_out;
    logic              number_closed;
    logic [DepthW-1:0] nest_depth;
    logic [2:0]        status;
  } result_t;

endpackage

FILE: rtl/core/jst_if.sv
// Valid/ready channel interfaces for input bytes and token events.
interface jst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface jst_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_res;
  logic [7:0] char_out;
  logic       number_closed;
  logic [5:0] nest_depth;
  logic [2:0] status;
  modport source (output valid, event_res, char_out, number_closed, nest_depth, status,
                  input ready);
  modport sink   (input valid, event_res, char_out, number_closed, nest_depth, status,
                  output ready);
endinterface

FILE: rtl/core/jst_front.sv
// Front end: accepts bytes, classifies them and fills a short queue.
module jst_front import jst_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic   in_end_i,
  output logic   q_valid_o,
  input  logic   q_pop_i,
  output item_t  q_item_o
);
  item_t mem_q [QDepth];
  logic  wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic  push;
  item_t it;

  assign in_ready_o = (cnt_q != 2'(QDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_q];

  always_comb begin
    it.text_byte   = in_byte_i;
    it.end_of_text = in_end_i;
    it.is_ws    = (in_byte_i == 8'h20) || (in_byte_i == 8'h09) ||
                  (in_byte_i == 8'h0A) || (in_byte_i == 8'h0D);
    it.is_digit = (in_byte_i >= "0") && (in_byte_i <= "9");
    it.is_exp   = (in_byte_i == "e") || (in_byte_i == "E");
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = q_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      wr_q <= wr_d; rd_q <= rd_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= it;
  end
endmodule

FILE: rtl/core/jst_back.sv
// Back end: parser state machine, container stack and output register.
module jst_back import jst_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  output logic    q_pop_o,
  input  item_t   q_item_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_res_o
);
  mode_e mode_q, mode_d;
  logic [2:0] lit_q, lit_d, ph_q, ph_d, err_q, err_d;
  logic esc_q, esc_d;
  logic [DepthW-1:0] dep_q, dep_d;
  logic [MaxDepth-1:0] stk_q;
  logic push_en, push_kind;
  logic ov_q;
  result_t res_q, res_d;
  logic step;
  logic [7:0] b;
  logic ws, dig, ex, closed, top;
  logic [3:0] ev;
  logic [7:0] ch;
  logic [2:0] st;
  logic [7:0] exp_ch;
  logic [2:0] lit_len;
  logic [3:0] lit_ev;

  assign q_pop_o = q_valid_i && (!ov_q || out_ready_i);
  assign step = q_pop_o;
  assign out_valid_o = ov_q;
  assign out_res_o = res_q;

  always_comb begin
    b = q_item_i.text_byte; ws = q_item_i.is_ws;
    dig = q_item_i.is_digit; ex = q_item_i.is_exp;
    top = (dep_q != '0) ? stk_q[PtrW'(dep_q - 1'b1)] : 1'b0;
    exp_ch = 8'h00; lit_len = 3'd4; lit_ev = EV_NULL;
    unique case (mode_q)
      M_TRUE: begin
        lit_ev = EV_TRUE;
        case (lit_q) 3'd1: exp_ch = "r"; 3'd2: exp_ch = "u"; 3'd3: exp_ch = "e";
          default: exp_ch = 8'h00; endcase
      end
      M_FALSE: begin
        lit_ev = EV_FALSE; lit_len = 3'd5;
        case (lit_q) 3'd1: exp_ch = "a"; 3'd2: exp_ch = "l"; 3'd3: exp_ch = "s";
          3'd4: exp_ch = "e"; default: exp_ch = 8'h00; endcase
      end
      default: begin
        case (lit_q) 3'd1: exp_ch = "u"; 3'd2: exp_ch = "l"; 3'd3: exp_ch = "l";
          default: exp_ch = 8'h00; endcase
      end
    endcase
  end

  always_comb begin
    logic start; logic do_push; logic kind;
    mode_d = mode_q; lit_d = lit_q; ph_d = ph_q; esc_d = esc_q;
    dep_d = dep_q; err_d = err_q; ev = EV_NONE; ch = 8'h00; closed = 1'b0;
    st = err_q; push_en = 1'b0; push_kind = 1'b0;
    start = 1'b0; do_push = 1'b0; kind = 1'b0;
    if (q_item_i.end_of_text) begin
      if (err_q != 3'd0) st = err_q;
      else begin
        unique case (mode_q)
          M_VALUE, M_ARR_FIRST: st = ST_EXPECT;
          M_AFTER: st = (dep_q == '0) ? ST_OK : ST_INVALID;
          M_NUM: begin
            if (ph_q == 3'd1 || ph_q == 3'd2 || ph_q == 3'd4 || ph_q == 3'd7) begin
              closed = 1'b1;
              st = (dep_q == '0) ? ST_OK : ST_INVALID;
            end else st = ST_INVALID;
          end
          default: st = ST_INVALID;
        endcase
      end
      mode_d = M_VALUE; lit_d = '0; ph_d = '0; esc_d = 1'b0; dep_d = '0; err_d = '0;
    end else if (err_q == 3'd0) begin
      if (mode_q == M_NUM) begin
        ev = EV_NUM_CHAR;
        case (ph_q)
          3'd0: if (b == "0") ph_d = 3'd1; else if (dig) ph_d = 3'd2;
                else err_d = ST_INVALID;
          3'd1, 3'd2: begin
            if (dig && ph_q == 3'd2) ph_d = ph_q;
            else if (b == ".") ph_d = 3'd3;
            else if (ex) ph_d = 3'd5;
            else begin ev = EV_NONE; closed = 1'b1; end
          end
          3'd3: if (dig) ph_d = 3'd4; else err_d = ST_INVALID;
          3'd4: if (dig) ph_d = ph_q; else if (ex) ph_d = 3'd5;
                else begin ev = EV_NONE; closed = 1'b1; end
          3'd5: if (b == "+" || b == "-") ph_d = 3'd6; else if (dig) ph_d = 3'd7;
                else err_d = ST_INVALID;
          3'd6: if (dig) ph_d = 3'd7; else err_d = ST_INVALID;
          default: if (!dig) begin ev = EV_NONE; closed = 1'b1; end
        endcase
      end
      unique case (mode_q)
        M_NUM: if (closed) begin
          // Number ended: this byte is handled as after a value.
          if (ws) ev = EV_NONE;
          else if (dep_q == '0) err_d = ST_NOT_SINGULAR;
          else if (b == ",") begin mode_d = top ? M_KEY : M_VALUE; ev = EV_COMMA; end
          else if (b == "]" && !top) begin dep_d = dep_q - 1'b1; ev = EV_ARR_CLOSE;
            mode_d = M_AFTER; end
          else if (b == "}" && top) begin dep_d = dep_q - 1'b1; ev = EV_OBJ_CLOSE;
            mode_d = M_AFTER; end
          else err_d = ST_INVALID;
          if (!ws && !(b == ",") && !(b == "]" && !top) && !(b == "}" && top))
            mode_d = M_AFTER;
          else if (ws) mode_d = M_AFTER;
        end
        M_VALUE: if (!ws) start = 1'b1;
        M_ARR_FIRST: if (ws) ev = EV_NONE;
          else if (b == "]") begin dep_d = dep_q - 1'b1; mode_d = M_AFTER;
            ev = EV_ARR_CLOSE; end
          else start = 1'b1;
        M_OBJ_FIRST, M_KEY: if (ws) ev = EV_NONE;
          else if (b == "}" && mode_q == M_OBJ_FIRST) begin
            dep_d = dep_q - 1'b1; mode_d = M_AFTER; ev = EV_OBJ_CLOSE; end
          else if (b == "\"") begin mode_d = M_KEYSTR; esc_d = 1'b0; ev = EV_STR_OPEN; end
          else err_d = ST_INVALID;
        M_COLON: if (ws) ev = EV_NONE;
          else if (b == ":") begin mode_d = M_VALUE; ev = EV_COLON; end
          else err_d = ST_INVALID;
        M_AFTER: if (ws) ev = EV_NONE;
          else if (dep_q == '0) err_d = ST_NOT_SINGULAR;
          else if (b == ",") begin mode_d = top ? M_KEY : M_VALUE; ev = EV_COMMA; end
          else if (b == "]" && !top) begin dep_d = dep_q - 1'b1; ev = EV_ARR_CLOSE; end
          else if (b == "}" && top) begin dep_d = dep_q - 1'b1; ev = EV_OBJ_CLOSE; end
          else err_d = ST_INVALID;
        M_NULL, M_TRUE, M_FALSE: begin
          if (lit_q >= lit_len || b != exp_ch) err_d = ST_INVALID;
          else if (lit_q + 3'd1 == lit_len) begin
            lit_d = '0; mode_d = M_AFTER; ev = lit_ev;
          end else begin lit_d = lit_q + 3'd1; ev = EV_LIT_CHAR; end
        end
        M_STR, M_KEYSTR: begin
          if (esc_q) begin
            esc_d = 1'b0; ev = EV_STR_CHAR;
            case (b)
              "\"": ch = 8'h22; "\\": ch = 8'h5C; "/": ch = 8'h2F;
              "b": ch = 8'd8; "f": ch = 8'd12; "n": ch = 8'd10;
              "r": ch = 8'd13; "t": ch = 8'd9;
              default: begin err_d = ST_INVALID; ev = EV_NONE; end
            endcase
          end else if (b == "\"") begin
            ev = (mode_q == M_KEYSTR) ? EV_KEY_CLOSE : EV_STR_CLOSE;
            mode_d = (mode_q == M_KEYSTR) ? M_COLON : M_AFTER;
          end else if (b == "\\") esc_d = 1'b1;
          else begin ev = EV_STR_CHAR; ch = b; end
        end
        default: err_d = ST_INVALID;
      endcase
      if (start) begin
        case (b)
          "n": begin mode_d = M_NULL; lit_d = 3'd1; ev = EV_LIT_CHAR; end
          "t": begin mode_d = M_TRUE; lit_d = 3'd1; ev = EV_LIT_CHAR; end
          "f": begin mode_d = M_FALSE; lit_d = 3'd1; ev = EV_LIT_CHAR; end
          "\"": begin mode_d = M_STR; esc_d = 1'b0; ev = EV_STR_OPEN; end
          "[": begin do_push = 1'b1; kind = 1'b0; end
          "{": begin do_push = 1'b1; kind = 1'b1; end
          "-": begin mode_d = M_NUM; ph_d = 3'd0; ev = EV_NUM_CHAR; end
          default: if (b == "0") begin mode_d = M_NUM; ph_d = 3'd1; ev = EV_NUM_CHAR; end
            else if (dig) begin mode_d = M_NUM; ph_d = 3'd2; ev = EV_NUM_CHAR; end
            else err_d = ST_INVALID;
        endcase
      end
      if (do_push) begin
        if (dep_q >= DepthW'(MaxDepth)) err_d = ST_TOO_DEEP;
        else begin
          push_en = 1'b1; push_kind = kind; dep_d = dep_q + 1'b1;
          mode_d = kind ? M_OBJ_FIRST : M_ARR_FIRST;
          ev = kind ? EV_OBJ_OPEN : EV_ARR_OPEN;
        end
      end
      if (err_d != 3'd0) ev = EV_NONE;
      st = err_d;
    end
    if (ev != EV_STR_CHAR) ch = 8'h00;
    res_d.event_res = ev; res_d.char_out = ch; res_d.number_closed = closed;
    res_d.nest_depth = q_item_i.end_of_text ? '0 : dep_d;
    res_d.status = st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_VALUE; lit_q <= '0; ph_q <= '0; esc_q <= 1'b0;
      dep_q <= '0; err_q <= '0; ov_q <= 1'b0;
    end else begin
      if (step) begin
        mode_q <= mode_d; lit_q <= lit_d; ph_q <= ph_d; esc_q <= esc_d;
        dep_q <= dep_d; err_q <= err_d;
      end
      if (step) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) res_q <= res_d;
    if (step && push_en) stk_q[PtrW'(dep_q)] <= push_kind;
  end
endmodule

FILE: rtl/core/json_syntax_tokenizer_core.sv
// Top level of the streaming JSON syntax tokenizer.
// The parser registers a byte's token event once the byte leaves the queue.
// Throughput: one byte per cycle while the output sink holds ready high.
// A two-entry queue separates byte intake from the parser, and one output
// register holds the result, so either side may stall independently.
// Reset (rst_ni low, asynchronous) empties the queue and clears parser state.
module json_syntax_tokenizer_core import jst_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  jst_in_if.sink    in_if,
  jst_out_if.source out_if
);
  // Queue between classifier and parser.
  logic  q_valid, q_pop;
  item_t q_item;
  result_t res;

  jst_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid), .in_ready_o (in_if.ready),
    .in_byte_i (in_if.text_byte), .in_end_i (in_if.end_of_text),
    .q_valid_o (q_valid), .q_pop_i (q_pop), .q_item_o (q_item)
  );

  // The parser retires one queued byte per transfer slot of the output.
  jst_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid), .q_pop_o (q_pop), .q_item_i (q_item),
    .out_valid_o (out_if.valid), .out_ready_i (out_if.ready), .out_res_o (res)
  );

  assign out_if.event_res     = res.event_res;
  assign out_if.char_out      = res.char_out;
  assign out_if.number_closed = res.number_closed;
  assign out_if.nest_depth    = res.nest_depth;
  assign out_if.status        = res.status;
endmodule
